[hdl/sbt_pkg.sv]
// Shared types, codes and address compare helpers for the socket binding table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

  localparam int ENTRIES_DEF = 64;

  // Operation codes
  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_FIND      = 2'd1;
  localparam logic [1:0] OP_REMOVE    = 2'd2;
  localparam logic [1:0] OP_FREE_PORT = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_ADDR_MODE = 2'd0;
  localparam logic [1:0] CFG_EPH_MIN   = 2'd1;
  localparam logic [1:0] CFG_EPH_MAX   = 2'd2;

  localparam logic [15:0] EPH_MIN_RST = 16'd49152;
  localparam logic [15:0] EPH_MAX_RST = 16'd65535;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [15:0] socket_id;
  } sbt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] socket_out;
    logic [15:0] port_out;
  } sbt_out_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [15:0] socket;
    logic [31:0] stamp;
  } sbt_entry_t;

  // All-zero "any" address under the current mode
  function automatic logic addr_any(input logic mode, input logic [63:0] hi,
                                    input logic [63:0] lo);
    addr_any = mode ? ((hi == 64'd0) && (lo == 64'd0)) : (lo[31:0] == 32'd0);
  endfunction

  function automatic logic addr_eq(input logic mode,
                                   input logic [63:0] ahi, input logic [63:0] alo,
                                   input logic [63:0] bhi, input logic [63:0] blo);
    addr_eq = mode ? ((ahi == bhi) && (alo == blo)) : (alo[31:0] == blo[31:0]);
  endfunction

endpackage

`default_nettype wire

[hdl/sbt_entry_ram.sv]
// Entry store of the socket binding table: one write port, one read port,
// read data registered. Depends on sbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbt_entry_ram
  import sbt_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int AW    = 6
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire sbt_entry_t wr_data,
  input  wire logic       rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output sbt_entry_t      rd_data
);

  sbt_entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/socket_binding_table.sv]
// Socket binding table: maps (address, port) to socket handles. Every word
// runs one or more scan passes over the entry store, one entry read per cycle
// (a free-port search with an empty port range runs none). Insert, find and
// remove take one pass; a free-port search takes one pass per port tried,
// at most ENTRIES + 1 passes, since each busy port needs one live entry.
// The rate is set by the single read port of the entry memory. A result waits
// in an output register; the next word is taken once the current one is done.
// No clearing pass: valid bits are cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module socket_binding_table
  import sbt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire sbt_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output sbt_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0] LAST_CNT = (IW+1)'(ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  state_t          state_r;
  sbt_in_t         req_r;
  sbt_out_t        res_r;
  sbt_out_t        out_r;
  logic            out_valid_r;
  logic [ENTRIES-1:0] valid_r;
  logic [31:0]     stamp_r;
  logic            mode_r;
  logic [15:0]     eph_min_r;
  logic [15:0]     eph_max_r;
  logic [15:0]     cand_r;
  logic [IW:0]     issue_r;
  logic            p1_vld_r;
  logic [IW-1:0]   p1_idx_r;
  logic            p1_vbit_r;
  logic            found_r;
  logic [IW-1:0]   best_idx_r;
  logic [31:0]     best_age_r;
  logic [15:0]     best_sock_r;
  logic            hit_r;
  logic            free_found_r;
  logic [IW-1:0]   free_idx_r;

  sbt_entry_t      ent;
  sbt_entry_t      wr_data;
  logic            rd_en;
  logic            wr_en;
  logic            pass_end;
  logic [15:0]     port_q;
  logic            loose;
  logic            exact;
  logic            match;
  logic [31:0]     age;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Entry memory access
  assign rd_en = (state_r == S_SCAN) && (issue_r < LAST_CNT);
  assign pass_end = (state_r == S_SCAN) && !p1_vld_r && (issue_r == LAST_CNT);
  assign wr_en = pass_end && (req_r.op == OP_INSERT) && !found_r && free_found_r;
  assign wr_data = '{addr_hi: req_r.addr_hi, addr_lo: req_r.addr_lo, port: req_r.port,
                     socket: req_r.socket_id, stamp: stamp_r};

  sbt_entry_ram #(.DEPTH(ENTRIES), .AW(IW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IW-1:0]),
    .rd_data (ent)
  );

  // Compare the returned entry against the request
  always_comb begin
    port_q = (req_r.op == OP_FREE_PORT) ? cand_r : req_r.port;
    exact  = addr_eq(mode_r, ent.addr_hi, ent.addr_lo, req_r.addr_hi, req_r.addr_lo);
    loose  = addr_any(mode_r, ent.addr_hi, ent.addr_lo) ||
             addr_any(mode_r, req_r.addr_hi, req_r.addr_lo) || exact;
    match  = p1_vbit_r && (ent.port == port_q) &&
             ((req_r.op == OP_REMOVE) ? exact : loose);
    age    = stamp_r - ent.stamp;
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
      valid_r     <= '0;
      stamp_r     <= 32'd0;
      mode_r      <= 1'b0;
      eph_min_r   <= EPH_MIN_RST;
      eph_max_r   <= EPH_MAX_RST;
      issue_r     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ADDR_MODE: mode_r    <= cfg_data[0];
          CFG_EPH_MIN:   eph_min_r <= cfg_data;
          CFG_EPH_MAX:   eph_max_r <= cfg_data;
          default: ;
        endcase
      end
      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r        <= in_data;
            cand_r       <= eph_min_r;
            issue_r      <= '0;
            p1_vld_r     <= 1'b0;
            found_r      <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            if ((in_data.op == OP_FREE_PORT) && (eph_min_r > eph_max_r)) begin
              res_r   <= '{status: ST_MISS, socket_out: 16'd0, port_out: 16'd0};
              state_r <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Advance the read pointer
          p1_vld_r  <= (issue_r < LAST_CNT);
          p1_idx_r  <= issue_r[IW-1:0];
          p1_vbit_r <= valid_r[issue_r[IW-1:0]];
          if (issue_r < LAST_CNT) begin
            issue_r <= issue_r + 1'b1;
          end
          // Evaluate the entry read last cycle
          if (p1_vld_r) begin
            if (match) begin
              hit_r <= 1'b1;
              if (!found_r || (age > best_age_r)) begin
                found_r     <= 1'b1;
                best_idx_r  <= p1_idx_r;
                best_age_r  <= age;
                best_sock_r <= ent.socket;
              end
            end
            if (!p1_vbit_r && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= p1_idx_r;
            end
          end
          if (pass_end) begin
            // Stay in the scan only when another port is to be tried
            if (!((req_r.op == OP_FREE_PORT) && hit_r && (cand_r != eph_max_r))) begin
              state_r <= S_OUT;
            end
            case (req_r.op)
              OP_INSERT: begin
                if (found_r) begin
                  res_r <= '{status: ST_MISS, socket_out: 16'd0, port_out: 16'd0};
                end else if (!free_found_r) begin
                  res_r <= '{status: ST_FULL, socket_out: 16'd0, port_out: 16'd0};
                end else begin
                  res_r <= '{status: ST_OK, socket_out: 16'd0, port_out: 16'd0};
                  valid_r[free_idx_r] <= 1'b1;
                  stamp_r <= stamp_r + 32'd1;
                end
              end
              OP_FIND, OP_REMOVE: begin
                if (found_r) begin
                  res_r <= '{status: ST_OK, socket_out: best_sock_r, port_out: 16'd0};
                  if (req_r.op == OP_REMOVE) begin
                    valid_r[best_idx_r] <= 1'b0;
                  end
                end else begin
                  res_r <= '{status: ST_MISS, socket_out: 16'd0, port_out: 16'd0};
                end
              end
              default: begin
                if (!hit_r) begin
                  res_r <= '{status: ST_OK, socket_out: 16'd0, port_out: cand_r};
                end else if (cand_r == eph_max_r) begin
                  res_r <= '{status: ST_MISS, socket_out: 16'd0, port_out: 16'd0};
                end else begin
                  // Try the next port
                  cand_r       <= cand_r + 16'd1;
                  issue_r      <= '0;
                  found_r      <= 1'b0;
                  hit_r        <= 1'b0;
                  free_found_r <= 1'b0;
                end
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ins_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !valid_r[free_idx_r])
    else $error("insert into a live slot");
  a_rm_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_end && (req_r.op == OP_REMOVE) && found_r) |-> valid_r[best_idx_r])
    else $error("remove of a dead slot");
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(stamp_r))
    else $error("stamp moved without insert");
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> (state_r == S_SCAN))
    else $error("read pipe busy outside a scan");
`endif

endmodule

`default_nettype wire

[tb/tb_socket_binding_table.sv]
// Testbench for the socket binding table: random and directed words against a
// behavioural predictor of the binding store. Depends on sbt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_socket_binding_table;
  import sbt_pkg::*;

  localparam int NSLOT = 64;
  // Register index beyond the list, written to check it is ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sbt_in_t in_data;
  logic out_valid;
  logic out_ready;
  sbt_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  socket_binding_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted table contents and settings
  logic        bind_used [NSLOT];
  sbt_entry_t  bind_slot [NSLOT];
  logic [31:0] bind_stamp_next;
  logic        mode_v6;
  logic [15:0] eph_lo;
  logic [15:0] eph_hi;

  sbt_in_t  pending_words [$];
  sbt_out_t awaited_results [$];
  int       mismatches;
  int       cycle_count;
  logic     in_idle_ok;
  logic     out_idle_ok;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic is_any(logic [63:0] hi, logic [63:0] lo);
    return mode_v6 ? (hi == 0 && lo == 0) : (lo[31:0] == 0);
  endfunction

  function automatic logic same_addr(logic [63:0] ah, logic [63:0] al,
                                     logic [63:0] bh, logic [63:0] bl);
    return mode_v6 ? (ah == bh && al == bl) : (al[31:0] == bl[31:0]);
  endfunction

  function automatic logic wild_hit(int s, logic [63:0] hi, logic [63:0] lo);
    return is_any(bind_slot[s].addr_hi, bind_slot[s].addr_lo) || is_any(hi, lo) ||
           same_addr(bind_slot[s].addr_hi, bind_slot[s].addr_lo, hi, lo);
  endfunction

  // Oldest matching live slot, or -1
  function automatic int oldest_binding(logic [63:0] hi, logic [63:0] lo,
                                        logic [15:0] port, logic exact);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    logic hit;
    best = -1;
    best_age = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (bind_used[s] && bind_slot[s].port == port) begin
        hit = exact ? same_addr(bind_slot[s].addr_hi, bind_slot[s].addr_lo, hi, lo)
                    : wild_hit(s, hi, lo);
        age = bind_stamp_next - bind_slot[s].stamp;
        if (hit && (best < 0 || age > best_age)) begin
          best = s;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  // Apply one word to the predicted table and return its result
  function automatic sbt_out_t bind_table_step(sbt_in_t w);
    sbt_out_t r;
    int k;
    int slot;
    logic busy [65536];
    r = '{status: ST_MISS, socket_out: 16'd0, port_out: 16'd0};
    case (w.op)
      OP_INSERT: begin
        if (oldest_binding(w.addr_hi, w.addr_lo, w.port, 1'b0) < 0) begin
          slot = -1;
          for (int s = NSLOT - 1; s >= 0; s--) if (!bind_used[s]) slot = s;
          if (slot < 0) r.status = ST_FULL;
          else begin
            bind_used[slot] = 1'b1;
            bind_slot[slot] = '{addr_hi: w.addr_hi, addr_lo: w.addr_lo, port: w.port,
                                socket: w.socket_id, stamp: bind_stamp_next};
            bind_stamp_next++;
            r.status = ST_OK;
          end
        end
      end
      OP_FIND, OP_REMOVE: begin
        k = oldest_binding(w.addr_hi, w.addr_lo, w.port, w.op == OP_REMOVE);
        if (k >= 0) begin
          r.status = ST_OK;
          r.socket_out = bind_slot[k].socket;
          if (w.op == OP_REMOVE) bind_used[k] = 1'b0;
        end
      end
      default: begin
        for (int p = 0; p < 65536; p++) busy[p] = 1'b0;
        for (int s = 0; s < NSLOT; s++)
          if (bind_used[s] && wild_hit(s, w.addr_hi, w.addr_lo)) busy[bind_slot[s].port] = 1'b1;
        for (int p = eph_lo; p <= eph_hi; p++) begin
          if (!busy[p]) begin
            r.status = ST_OK;
            r.port_out = p[15:0];
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Driver: present queued words, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) awaited_results.push_back(bind_table_step(in_data));
      if (pending_words.size() > 0 && (in_idle_ok ? $urandom_range(99) >= 25 : 1'b1)) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk) begin
    sbt_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_data.status !== exp_r.status || out_data.socket_out !== exp_r.socket_out ||
              out_data.port_out !== exp_r.port_out) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", exp_r, out_data);
          end
        end
      end
      out_ready <= out_idle_ok ? ($urandom_range(99) >= 25) : 1'b1;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3000000) begin
      $display("socket_binding_table: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Addresses from a small pool so that collisions happen
  function automatic sbt_in_t make_word(logic [1:0] op);
    sbt_in_t w;
    int pick;
    pick = $urandom_range(9);
    w.op = op;
    w.addr_hi = (pick < 2) ? 64'd0 : (pick < 5 ? {48'd0, 16'(pick)} : rnd64());
    w.addr_lo = (pick < 1) ? 64'd0 : (pick < 7 ? {32'(pick), 32'(pick & 3)} : rnd64());
    w.port = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'(49152 + $urandom_range(5));
    w.socket_id = 16'($urandom());
    return w;
  endfunction

  task automatic drain_and_wait();
    while (pending_words.size() > 0 || in_valid || awaited_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write one register, then hold the port idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ADDR_MODE) mode_v6 = val[0];
    else if (idx == CFG_EPH_MIN) eph_lo = val;
    else if (idx == CFG_EPH_MAX) eph_hi = val;
    @(posedge clk);
  endtask

  initial begin
    sbt_in_t w;
    logic [1:0] opr;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ADDR_MODE;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    in_idle_ok = 1'b1;
    out_idle_ok = 1'b1;
    for (int s = 0; s < NSLOT; s++) begin
      bind_used[s] = 1'b0;
      bind_slot[s] = '0;
    end
    bind_stamp_next = 0;
    mode_v6 = 1'b0;
    eph_lo = EPH_MIN_RST;
    eph_hi = EPH_MAX_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, duplicates, wildcard, exact remove
    pending_words.push_back('{OP_FREE_PORT, 64'd0, 64'd0, 16'd0, 16'd0});
    pending_words.push_back('{OP_INSERT, '1, '1, 16'hFFFF, 16'hFFFF});
    pending_words.push_back('{OP_INSERT, 64'd0, 64'd0, 16'd0, 16'd1});
    pending_words.push_back('{OP_INSERT, 64'd5, 64'd7, 16'd0, 16'd2});
    pending_words.push_back('{OP_FIND, 64'd9, 64'd9, 16'd0, 16'd0});
    pending_words.push_back('{OP_FIND, '1, '1, 16'hFFFF, 16'd0});
    pending_words.push_back('{OP_REMOVE, 64'd1, 64'hFFFF_FFFF, 16'hFFFF, 16'd0});
    pending_words.push_back('{OP_REMOVE, 64'd0, 64'd0, 16'd0, 16'd0});
    pending_words.push_back('{OP_REMOVE, 64'd0, 64'd0, 16'd0, 16'd0});
    pending_words.push_back('{OP_FREE_PORT, '1, '1, '1, '1});
    // Fill the table, then hit it when full
    for (int i = 0; i < 66; i++)
      pending_words.push_back('{OP_INSERT, 64'd0, 64'(i + 1), 16'(49152 + (i & 1)), 16'(i)});
    pending_words.push_back('{OP_FREE_PORT, 64'd0, 64'd3, 16'd0, 16'd0});
    for (int i = 0; i < 66; i++)
      pending_words.push_back('{OP_REMOVE, 64'd0, 64'(i + 1), 16'(49152 + (i & 1)), 16'd0});
    drain_and_wait();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ADDR_MODE, 16'd1); write_reg(CFG_EPH_MIN, 16'd0);
                 write_reg(CFG_EPH_MAX, 16'd3); end
        1: begin write_reg(CFG_EPH_MIN, 16'd10); write_reg(CFG_EPH_MAX, 16'd5); end
        2: begin write_reg(CFG_ADDR_MODE, 16'd0); write_reg(CFG_EPH_MIN, 16'd49152);
                 write_reg(CFG_EPH_MAX, 16'd49156); end
        3: begin write_reg(CFG_EPH_MIN, 16'hFFFE); write_reg(CFG_EPH_MAX, 16'hFFFF); end
        4: begin write_reg(CFG_ADDR_MODE, 16'd1); write_reg(CFG_EPH_MIN, 16'd49152);
                 write_reg(CFG_EPH_MAX, 16'd49158); end
        default: begin write_reg(CFG_ADDR_MODE, 16'hFFFE); write_reg(CFG_UNUSED, 16'd0);
                 write_reg(CFG_EPH_MIN, 16'hFFFF); write_reg(CFG_EPH_MAX, 16'hFFFF); end
      endcase
      // No idling during one phase
      in_idle_ok = (ph != 2);
      out_idle_ok = (ph != 2);
      for (int i = 0; i < 140; i++) begin
        opr = ($urandom_range(9) < 4) ? OP_INSERT : 2'($urandom_range(3));
        pending_words.push_back(make_word(opr));
      end
      drain_and_wait();
    end

    if (mismatches == 0) begin
      $display("socket_binding_table: match");
    end else begin
      $display("socket_binding_table: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sbt_pkg.sv
hdl/sbt_entry_ram.sv
hdl/socket_binding_table.sv
tb/tb_socket_binding_table.sv
